@@ rtl/tomf_pkg.sv @@
// ----------------------------------------------------------------------------
// tomf_pkg
// Shared types, sizes and helpers for the timestamp-ordered multi-source FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tomf_pkg;

  // Block sizing
  localparam int NUM_SOURCES = 4;
  localparam int FIFO_DEPTH  = 16;
  localparam int DATA_WIDTH  = 32;

  // Fixed field widths of the request and response beats
  localparam int STAMP_W     = 32;
  localparam int PORT_DATA_W = 32;
  localparam int SRC_FIELD_W = 2;
  localparam int OCC_W       = 7;

  // Derived widths
  localparam int SRC_IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRY_W   = STAMP_W + DATA_WIDTH;

  typedef logic [DATA_WIDTH-1:0]  data_t;
  typedef logic [STAMP_W-1:0]     stamp_t;
  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [FILL_W-1:0]      fill_t;
  typedef logic [SRC_IDX_W-1:0]   src_idx_t;
  typedef logic [OCC_W-1:0]       occ_t;

  // Request kinds
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_kind_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic                    req_type;
    logic [SRC_FIELD_W-1:0]  source_id;
    logic [PORT_DATA_W-1:0]  data_value;
  } req_item_t;

  typedef struct packed {
    status_t                 status;
    logic [PORT_DATA_W-1:0]  dequeued_value;
    logic [SRC_FIELD_W-1:0]  from_source;
    stamp_t                  item_stamp;
    occ_t                    occupancy;
  } rsp_item_t;

  // One stored item
  typedef struct packed {
    stamp_t stamp;
    data_t  value;
  } entry_t;

  // Control into one per-source FIFO lane
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wr_entry;
  } lane_cmd_t;

  // Status out of one per-source FIFO lane
  typedef struct packed {
    logic   not_empty;
    logic   full;
    entry_t head;
  } lane_stat_t;

  // Outcome of the oldest-head search
  typedef struct packed {
    logic     found;
    src_idx_t idx;
    entry_t   entry;
  } pick_t;

  // Wrapping stamp order: a is older than b when a - b has its top bit set
  function automatic logic older(stamp_t a, stamp_t b);
    stamp_t diff;
    diff = a - b;
    return diff[STAMP_W-1];
  endfunction

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Port data to stored width
  function automatic data_t to_data(logic [PORT_DATA_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Stored width back to port data
  function automatic logic [PORT_DATA_W-1:0] from_data(data_t d);
    logic [63:0] w;
    w = 64'(d);
    return w[PORT_DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/timestamp_ordered_multi_fifo.sv @@
// ----------------------------------------------------------------------------
// timestamp_ordered_multi_fifo
// Per-source FIFOs merged on dequeue by oldest timestamp.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle and returns exactly one response
// beat per request, in request order. A request beat is registered on accept
// and resolved into the result register once that register is free or is
// draining, and the block sustains one beat per cycle as long as the response
// side keeps up; the result register parts the two sides so a stalled response
// beat does not lose the request beat held in the input register. Each
// source has its own FIFO of FIFO_DEPTH entries in a RAM whose read port
// always fetches the head that will stand next cycle, which lets dequeues run
// back to back. Every request, accepted into a FIFO or not, advances the
// shared 32-bit stamp counter. A dequeue returns the head with the oldest
// stamp under wrapping compare, ties to the lower source. The RAMs need no
// clearing pass: the fill counts guard every read.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_ordered_multi_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire tomf_pkg::req_item_t  req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output tomf_pkg::rsp_item_t       rsp
);

  import tomf_pkg::*;

  // Input register
  req_item_t  hold;
  logic       hold_valid;

  // Shared state
  stamp_t     stamp_counter;
  occ_t       total_count;
  occ_t       total_count_next;

  rsp_item_t  rsp_next;
  logic       fire;
  logic       is_enq;
  logic       sel_full;
  logic       enq_ok;
  logic       deq_ok;

  lane_cmd_t  lane_cmd  [NUM_SOURCES];
  lane_stat_t lane_stat [NUM_SOURCES];
  pick_t      pick;

  // Resolve the held beat whenever the result register is free or draining
  assign fire      = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  // Per-source FIFOs
  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_lane
    tomf_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (lane_cmd[g]),
      .stat (lane_stat[g])
    );
  end

  tomf_oldest u_oldest (
    .stat (lane_stat),
    .pick (pick)
  );

  // Decode the held beat; a source with no lane counts as full
  always_comb begin
    is_enq   = (hold.req_type == REQ_ENQ);
    sel_full = 1'b1;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (int'(hold.source_id) == s) begin
        sel_full = lane_stat[s].full;
      end
    end
    enq_ok = fire && is_enq && !sel_full;
    deq_ok = fire && !is_enq && pick.found;
  end

  // Drive lane commands
  always_comb begin
    for (int s = 0; s < NUM_SOURCES; s++) begin
      lane_cmd[s].push           = enq_ok && (int'(hold.source_id) == s);
      lane_cmd[s].pop            = deq_ok && (pick.idx == SRC_IDX_W'(s));
      lane_cmd[s].wr_entry.stamp = stamp_counter;
      lane_cmd[s].wr_entry.value = to_data(hold.data_value);
    end
  end

  // Occupancy after this request, kept modulo the field width
  always_comb begin
    priority if (enq_ok) begin
      total_count_next = total_count + OCC_W'(1);
    end else if (deq_ok) begin
      total_count_next = total_count - OCC_W'(1);
    end else begin
      total_count_next = total_count;
    end
  end

  // Build the response beat
  always_comb begin
    rsp_next           = '0;
    rsp_next.occupancy = total_count_next;
    if (is_enq) begin
      if (sel_full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status     = ST_ENQ;
        rsp_next.item_stamp = stamp_counter;
      end
    end else begin
      if (pick.found) begin
        rsp_next.status         = ST_DEQ;
        rsp_next.dequeued_value = from_data(pick.entry.value);
        rsp_next.from_source    = SRC_FIELD_W'(pick.idx);
        rsp_next.item_stamp     = pick.entry.stamp;
      end else begin
        rsp_next.status = ST_EMPTY;
      end
    end
  end

  // Advance shared state once per resolved beat
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_counter <= '0;
      total_count   <= '0;
    end else if (fire) begin
      stamp_counter <= stamp_counter + STAMP_W'(1);
      total_count   <= total_count_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tomf_ram.sv @@
// ----------------------------------------------------------------------------
// tomf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tomf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tomf_lane.sv @@
// ----------------------------------------------------------------------------
// tomf_lane
// One per-source FIFO: pointers, fill count, entry RAM and head bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module tomf_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tomf_pkg::lane_cmd_t cmd,
  output tomf_pkg::lane_stat_t     stat
);

  import tomf_pkg::*;

  ptr_t   head_ptr;
  ptr_t   head_ptr_next;
  ptr_t   tail_ptr;
  fill_t  fill;
  logic   byp_hit;
  entry_t byp_entry;
  logic [ENTRY_W-1:0] rd_word;

  // Read the head that will stand after this cycle
  assign head_ptr_next = cmd.pop ? ptr_inc(head_ptr) : head_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      fill     <= '0;
      byp_hit  <= 1'b0;
    end else begin
      head_ptr <= head_ptr_next;
      if (cmd.push) begin
        tail_ptr <= ptr_inc(tail_ptr);
      end
      if (cmd.push) begin
        fill <= fill + FILL_W'(1);
      end else if (cmd.pop) begin
        fill <= fill - FILL_W'(1);
      end
      // A write landing on the slot being read wins over the stale read
      byp_hit <= cmd.push && (tail_ptr == head_ptr_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_entry <= cmd.wr_entry;
  end

  tomf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_ptr),
    .wdata (cmd.wr_entry),
    .raddr (head_ptr_next),
    .rdata (rd_word)
  );

  always_comb begin
    stat.not_empty = (fill != '0);
    stat.full      = (fill == FILL_W'(FIFO_DEPTH));
    stat.head      = byp_hit ? byp_entry : entry_t'(rd_word);
  end

endmodule

`default_nettype wire

@@ rtl/tomf_oldest.sv @@
// ----------------------------------------------------------------------------
// tomf_oldest
// Scan the lane heads in source order and pick the oldest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tomf_oldest (
  input  wire tomf_pkg::lane_stat_t stat [tomf_pkg::NUM_SOURCES],
  output tomf_pkg::pick_t           pick
);

  import tomf_pkg::*;

  // Strictly older replaces, so ties go to the lower source
  always_comb begin
    pick = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (stat[s].not_empty &&
          (!pick.found || older(stat[s].head.stamp, pick.entry.stamp))) begin
        pick.found = 1'b1;
        pick.idx   = SRC_IDX_W'(s);
        pick.entry = stat[s].head;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tomf_checker.sv @@
// ----------------------------------------------------------------------------
// tomf_checker
// Port-level checks on ordering, stamping and occupancy of response beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tomf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire tomf_pkg::req_item_t req,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire tomf_pkg::rsp_item_t rsp
);

  import tomf_pkg::*;

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pending;
  stamp_t     rsp_count;
  occ_t       last_occ;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Track beats in flight, responses delivered and the last occupancy seen
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      rsp_count <= '0;
      last_occ  <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
      if (rsp_fire) begin
        rsp_count <= rsp_count + STAMP_W'(1);
        last_occ  <= rsp.occupancy;
      end
    end
  end

  // Hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // No response without a request in flight, and at most two in flight
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || pending != 2'd0) && pending != 2'd3)
    else $error("response beat without a matching request");

  // An enqueue is stamped with the number of requests before it
  a_enq_stamp: assert property (@(posedge clk) disable iff (rst)
    rsp_fire && rsp.status == ST_ENQ |-> rsp.item_stamp == rsp_count)
    else $error("enqueue stamp out of sequence");

  // Occupancy steps by the outcome of each request
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |->
      ((rsp.status == ST_ENQ) && (rsp.occupancy == OCC_W'(last_occ + OCC_W'(1)))) ||
      ((rsp.status == ST_DEQ) && (rsp.occupancy == OCC_W'(last_occ - OCC_W'(1)))) ||
      (((rsp.status == ST_EMPTY) || (rsp.status == ST_FULL)) &&
       (rsp.occupancy == last_occ)))
    else $error("occupancy does not follow response status");

endmodule

bind timestamp_ordered_multi_fifo tomf_checker u_checker (.*);

`default_nettype wire
